// ----- rtl/psc_pkg.sv -----
// Package for the clamped PID controller.
// Holds field widths, register indexes, reset values and the register file type.
// No dependencies.
package psc_pkg;

    localparam int GAIN_W     = 16;
    localparam int TARGET_W   = 16;
    localparam int BOUND_W    = 32;
    localparam int DRIVE_W    = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;
    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 4;

    localparam logic [REG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I        = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET        = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ACCUM_FLOOR   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ACCUM_CEILING = 3'd7;

    localparam logic signed [BOUND_W-1:0] BOUND_MIN = 32'sh8000_0000;
    localparam logic signed [BOUND_W-1:0] BOUND_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   gain_p;
        logic signed [GAIN_W-1:0]   gain_d;
        logic signed [GAIN_W-1:0]   gain_i;
        logic signed [TARGET_W-1:0] target;
        logic signed [BOUND_W-1:0]  drive_floor;
        logic signed [BOUND_W-1:0]  drive_ceiling;
        logic signed [BOUND_W-1:0]  accum_floor;
        logic signed [BOUND_W-1:0]  accum_ceiling;
    } t_cfg;

endpackage

// ----- rtl/psc_fifo.sv -----
// Small register-based queue used between the controller stages and at the output.
// Depends on nothing; DEPTH must be a power of two, at least two.
module psc_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/psc_front.sv -----
// Front part of the controller: accepts samples, forms error and measurement change.
// Keeps the previous sample. Depends on psc_pkg.
module psc_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ERR_W        = 17,
    parameter int DELTA_W      = 17
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_measurement,
    input  logic signed [psc_pkg::TARGET_W-1:0] i_target,
    input  logic                              i_mid_full,
    output logic                              o_mid_push,
    output logic [ERR_W+DELTA_W-1:0]          o_item
);
    logic signed [SAMPLE_WIDTH-1:0] r_last_sample;
    logic signed [ERR_W-1:0]        w_error;
    logic signed [DELTA_W-1:0]      w_delta;

    assign o_mid_push = i_push && !i_mid_full;
    assign w_error    = ERR_W'(i_target) - ERR_W'(i_measurement);
    assign w_delta    = DELTA_W'(r_last_sample) - DELTA_W'(i_measurement);
    assign o_item     = {w_error, w_delta};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sample <= '0;
        end else if (o_mid_push) begin
            r_last_sample <= i_measurement;
        end
    end

endmodule

// ----- rtl/psc_back.sv -----
// Back part of the controller: gain multiplies, clamped integral, clamped drive sum.
// Holds the result queue. Depends on psc_pkg and psc_fifo.
module psc_back #(
    parameter int ERR_W          = 17,
    parameter int DELTA_W        = 17,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_mid_empty,
    input  logic [ERR_W+DELTA_W-1:0]          i_item,
    output logic                              o_mid_pop,
    input  psc_pkg::t_cfg                     i_cfg,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic signed [psc_pkg::DRIVE_W-1:0] o_drive
);
    localparam int PP_W  = ERR_W + psc_pkg::GAIN_W;
    localparam int DP_W  = DELTA_W + psc_pkg::GAIN_W;
    localparam int ACC_W = PP_W + 1;
    localparam int PD_W  = ((PP_W > DP_W) ? PP_W : DP_W) + 1;
    localparam int SUM_W = PD_W + 1;
    localparam int CNT_W = $clog2(psc_pkg::OUT_DEPTH + 1);

    logic signed [ERR_W-1:0]   w_error;
    logic signed [DELTA_W-1:0] w_delta;
    logic                      r_v1;
    logic                      r_v2;
    logic signed [PP_W-1:0]    r_prod_p;
    logic signed [DP_W-1:0]    r_prod_d;
    logic signed [PP_W-1:0]    r_prod_i;
    logic signed [PD_W-1:0]    r_pd;
    logic signed [PD_W-1:0]    n_pd;
    logic signed [psc_pkg::BOUND_W-1:0] r_acc;
    logic signed [psc_pkg::BOUND_W-1:0] n_acc;
    logic signed [ACC_W-1:0]   w_acc_sum;
    logic signed [SUM_W-1:0]   w_drive_sum;
    logic signed [psc_pkg::DRIVE_W-1:0] n_drive;
    logic [CNT_W-1:0]          w_out_count;
    logic                      w_out_full;
    logic [CNT_W:0]            w_in_flight;

    assign w_error = $signed(i_item[ERR_W+DELTA_W-1:DELTA_W]);
    assign w_delta = $signed(i_item[DELTA_W-1:0]);

    assign w_in_flight = (CNT_W+1)'(w_out_count) + (CNT_W+1)'(r_v1) + (CNT_W+1)'(r_v2);
    assign o_mid_pop   = !i_mid_empty && (w_in_flight < (CNT_W+1)'(psc_pkg::OUT_DEPTH));

    always_comb begin
        w_acc_sum = ACC_W'(r_prod_i >>> GAIN_FRAC_BITS) + ACC_W'(r_acc);
        if (w_acc_sum > ACC_W'(i_cfg.accum_ceiling)) begin
            n_acc = i_cfg.accum_ceiling;
        end else if (w_acc_sum < ACC_W'(i_cfg.accum_floor)) begin
            n_acc = i_cfg.accum_floor;
        end else begin
            n_acc = w_acc_sum[psc_pkg::BOUND_W-1:0];
        end
        n_pd = PD_W'(r_prod_p >>> GAIN_FRAC_BITS) + PD_W'(r_prod_d >>> GAIN_FRAC_BITS);
    end

    always_comb begin
        w_drive_sum = SUM_W'(r_pd) + SUM_W'(r_acc);
        if (w_drive_sum > SUM_W'(i_cfg.drive_ceiling)) begin
            n_drive = i_cfg.drive_ceiling;
        end else if (w_drive_sum < SUM_W'(i_cfg.drive_floor)) begin
            n_drive = i_cfg.drive_floor;
        end else begin
            n_drive = w_drive_sum[psc_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= o_mid_pop;
            r_v2 <= r_v1;
            if (r_v1) begin
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            r_prod_p <= PP_W'(w_error) * PP_W'(i_cfg.gain_p);
            r_prod_d <= DP_W'(w_delta) * DP_W'(i_cfg.gain_d);
            r_prod_i <= PP_W'(w_error) * PP_W'(i_cfg.gain_i);
        end
        if (r_v1) begin
            r_pd <= n_pd;
        end
    end

    psc_fifo #(
        .WIDTH (psc_pkg::DRIVE_W),
        .DEPTH (psc_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v2),
        .i_data  (n_drive),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (o_drive),
        .o_empty (o_empty),
        .o_count (w_out_count)
    );

    logic w_unused_full;
    assign w_unused_full = w_out_full;

endmodule

// ----- rtl/pid_step_clamped.sv -----
// Clamped PID controller: one measurement in, one drive value out per transaction.
// A sample passes the mid queue, product, sum and integral registers, then the result queue.
// Throughput is one transaction per cycle, set by the clamped integral, while results drain.
// Synchronous active-low reset clears the queues, the stored sample and the integral,
// and loads the gains and set point with zero and the bounds with the full 32-bit range.
// Depends on psc_pkg, psc_front, psc_fifo and psc_back.
module pid_step_clamped #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [psc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [psc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [psc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               push,
    output logic                               full,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_measurement,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [psc_pkg::DRIVE_W-1:0] o_drive
);
    localparam int ERR_W   = ((SAMPLE_WIDTH > psc_pkg::TARGET_W) ?
                              SAMPLE_WIDTH : psc_pkg::TARGET_W) + 1;
    localparam int DELTA_W = SAMPLE_WIDTH + 1;
    localparam int ITEM_W  = ERR_W + DELTA_W;

    psc_pkg::t_cfg                   r_cfg;
    logic [psc_pkg::REG_IDX_W-1:0]   w_idx;
    logic                            w_cfg_wr;
    logic                            w_mid_push;
    logic                            w_mid_pop;
    logic                            w_mid_empty;
    logic [ITEM_W-1:0]               w_front_item;
    logic [ITEM_W-1:0]               w_mid_item;

    assign pready   = 1'b1;
    assign w_idx    = paddr[psc_pkg::APB_ADDR_W-1:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p        <= '0;
            r_cfg.gain_d        <= '0;
            r_cfg.gain_i        <= '0;
            r_cfg.target        <= '0;
            r_cfg.drive_floor   <= psc_pkg::BOUND_MIN;
            r_cfg.drive_ceiling <= psc_pkg::BOUND_MAX;
            r_cfg.accum_floor   <= psc_pkg::BOUND_MIN;
            r_cfg.accum_ceiling <= psc_pkg::BOUND_MAX;
        end else if (w_cfg_wr) begin
            case (w_idx)
                psc_pkg::REG_GAIN_P:        r_cfg.gain_p        <= pwdata[15:0];
                psc_pkg::REG_GAIN_D:        r_cfg.gain_d        <= pwdata[15:0];
                psc_pkg::REG_GAIN_I:        r_cfg.gain_i        <= pwdata[15:0];
                psc_pkg::REG_TARGET:        r_cfg.target        <= pwdata[15:0];
                psc_pkg::REG_DRIVE_FLOOR:   r_cfg.drive_floor   <= pwdata;
                psc_pkg::REG_DRIVE_CEILING: r_cfg.drive_ceiling <= pwdata;
                psc_pkg::REG_ACCUM_FLOOR:   r_cfg.accum_floor   <= pwdata;
                psc_pkg::REG_ACCUM_CEILING: r_cfg.accum_ceiling <= pwdata;
                default:                    r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            psc_pkg::REG_GAIN_P:        prdata = {16'd0, r_cfg.gain_p};
            psc_pkg::REG_GAIN_D:        prdata = {16'd0, r_cfg.gain_d};
            psc_pkg::REG_GAIN_I:        prdata = {16'd0, r_cfg.gain_i};
            psc_pkg::REG_TARGET:        prdata = {16'd0, r_cfg.target};
            psc_pkg::REG_DRIVE_FLOOR:   prdata = r_cfg.drive_floor;
            psc_pkg::REG_DRIVE_CEILING: prdata = r_cfg.drive_ceiling;
            psc_pkg::REG_ACCUM_FLOOR:   prdata = r_cfg.accum_floor;
            psc_pkg::REG_ACCUM_CEILING: prdata = r_cfg.accum_ceiling;
            default:                    prdata = '0;
        endcase
    end

    psc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ERR_W        (ERR_W),
        .DELTA_W      (DELTA_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_measurement (i_measurement),
        .i_target      (r_cfg.target),
        .i_mid_full    (full),
        .o_mid_push    (w_mid_push),
        .o_item        (w_front_item)
    );

    psc_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (psc_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_front_item),
        .o_full  (full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_item),
        .o_empty (w_mid_empty),
        .o_count ()
    );

    psc_back #(
        .ERR_W          (ERR_W),
        .DELTA_W        (DELTA_W),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (w_mid_empty),
        .i_item      (w_mid_item),
        .o_mid_pop   (w_mid_pop),
        .i_cfg       (r_cfg),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_drive     (o_drive)
    );

endmodule

// ----- rtl/psc_checker.sv -----
// Port-level checks for the clamped PID controller, attached by a bind statement.
// Depends on psc_pkg and on the ports of pid_step_clamped.
module psc_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [psc_pkg::APB_ADDR_W-1:0]     paddr,
    input logic [psc_pkg::APB_DATA_W-1:0]     pwdata,
    input logic [psc_pkg::APB_DATA_W-1:0]     prdata,
    input logic                               pready,
    input logic                               push,
    input logic                               full,
    input logic signed [SAMPLE_WIDTH-1:0]     i_measurement,
    input logic                               empty,
    input logic                               pop,
    input logic signed [psc_pkg::DRIVE_W-1:0] o_drive
);
    logic w_unused;
    assign w_unused = psel ^ penable ^ pwrite ^ pready ^ push ^ (^i_measurement);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_drive))
        else $error("waiting result changed or vanished");

    a_first_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3))
        else $error("result appeared too soon after reset");

    a_bound_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(psel && penable && pwrite && pready) &&
        paddr == $past(paddr) && paddr[4] |-> prdata == $past(pwdata))
        else $error("bound register did not take the written value");

endmodule

bind pid_step_clamped psc_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_psc_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for pid_step_clamped: a queue-fed sample driver, a result monitor
// and an in-bench PID predictor. Registers are loaded over the APB-style port between phases.
// Depends on psc_pkg and the pid_step_clamped RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W     = 16;
    localparam int FRAC_BITS    = 8;
    localparam int STALL_CYCLES = 80;

    typedef enum int {
        SET_EXTREME, SET_NARROW, SET_CROSSED, SET_ANY, SET_EQUAL, SET_WINDUP
    } t_setting;

    typedef enum int {BND_NARROW, BND_CROSSED, BND_EQUAL, BND_ANY} t_bounds;

    logic                                 i_clk;
    logic                                 i_rst_n       = 1'b0;
    logic                                 psel          = 1'b0;
    logic                                 penable       = 1'b0;
    logic                                 pwrite        = 1'b0;
    logic [psc_pkg::APB_ADDR_W-1:0]       paddr         = '0;
    logic [psc_pkg::APB_DATA_W-1:0]       pwdata        = '0;
    logic [psc_pkg::APB_DATA_W-1:0]       prdata;
    logic                                 pready;
    logic                                 push          = 1'b0;
    logic                                 full;
    logic signed [SAMPLE_W-1:0]           i_measurement = '0;
    logic                                 empty;
    logic                                 pop           = 1'b0;
    logic signed [psc_pkg::DRIVE_W-1:0]   o_drive;

    logic signed [SAMPLE_W-1:0]           stim_q[$];
    logic signed [psc_pkg::DRIVE_W-1:0]   drive_q[$];
    logic signed [SAMPLE_W-1:0]           last_gen = '0;

    psc_pkg::t_cfg               pid_cfg;
    longint                      prev_meas = 0;
    longint                      integ     = 0;

    bit                          took_sample = 1'b0;
    bit                          rcv_hold    = 1'b0;
    bit                          stall_go    = 1'b0;
    int unsigned                 send_idle_pct = 7;
    int unsigned                 recv_idle_pct = 52;
    int                          samples_sent   = 0;
    int                          drives_checked = 0;
    int                          settings_used  = 0;
    int                          stalled_offers = 0;
    int                          errors         = 0;

    pid_step_clamped #(
        .SAMPLE_WIDTH   (SAMPLE_W),
        .GAIN_FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .i_measurement (i_measurement),
        .empty         (empty),
        .pop           (pop),
        .o_drive       (o_drive)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic logic signed [psc_pkg::DRIVE_W-1:0] next_drive(
        input logic signed [SAMPLE_W-1:0] meas
    );
        longint err;
        longint change;
        longint p_term;
        longint d_term;
        longint total;
        err    = longint'(pid_cfg.target) - longint'(meas);
        change = prev_meas - longint'(meas);
        p_term = (err * longint'(pid_cfg.gain_p)) >>> FRAC_BITS;
        d_term = (change * longint'(pid_cfg.gain_d)) >>> FRAC_BITS;
        integ  = clamp_to(integ + ((err * longint'(pid_cfg.gain_i)) >>> FRAC_BITS),
                          longint'(pid_cfg.accum_floor), longint'(pid_cfg.accum_ceiling));
        prev_meas = longint'(meas);
        total = clamp_to(p_term + d_term + integ,
                         longint'(pid_cfg.drive_floor), longint'(pid_cfg.drive_ceiling));
        return total[psc_pkg::DRIVE_W-1:0];
    endfunction

    function automatic logic signed [psc_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return 16'(int'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void bound_pair(input t_bounds kind,
                                       output logic signed [psc_pkg::BOUND_W-1:0] lo,
                                       output logic signed [psc_pkg::BOUND_W-1:0] hi);
        logic signed [psc_pkg::BOUND_W-1:0] a;
        logic signed [psc_pkg::BOUND_W-1:0] b;
        a = 32'($urandom);
        b = 32'($urandom);
        if (kind == BND_NARROW) begin
            a = int'($urandom_range(0, 2**21)) - 2**20;
            b = a + int'($urandom_range(0, 65536));
        end else if (kind == BND_EQUAL) begin
            b = a;
        end else if (kind == BND_CROSSED && a == b) begin
            b = a ^ 32'sh1;
        end
        if (kind == BND_ANY) begin
            lo = a;
            hi = b;
        end else if (kind == BND_CROSSED) begin
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
        end else begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] next_sample(input bit winding);
        if (winding) begin
            return 16'(int'($urandom_range(0, 768)) - 32768);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: last_gen = 16'($urandom);
            4, 5, 6:    last_gen = last_gen + 16'(int'($urandom_range(0, 64)) - 32);
            7:          last_gen = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default:    last_gen = pid_cfg.target + 16'(int'($urandom_range(0, 16)) - 8);
        endcase
        return last_gen;
    endfunction

    task automatic write_reg(input logic [psc_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        case (idx)
            psc_pkg::REG_GAIN_P:        pid_cfg.gain_p        = value[psc_pkg::GAIN_W-1:0];
            psc_pkg::REG_GAIN_D:        pid_cfg.gain_d        = value[psc_pkg::GAIN_W-1:0];
            psc_pkg::REG_GAIN_I:        pid_cfg.gain_i        = value[psc_pkg::GAIN_W-1:0];
            psc_pkg::REG_TARGET:        pid_cfg.target        = value[psc_pkg::TARGET_W-1:0];
            psc_pkg::REG_DRIVE_FLOOR:   pid_cfg.drive_floor   = value;
            psc_pkg::REG_DRIVE_CEILING: pid_cfg.drive_ceiling = value;
            psc_pkg::REG_ACCUM_FLOOR:   pid_cfg.accum_floor   = value;
            psc_pkg::REG_ACCUM_CEILING: pid_cfg.accum_ceiling = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // The upper halves of the 16-bit registers carry junk that the block must drop.
    task automatic write_all(input psc_pkg::t_cfg c);
        write_reg(psc_pkg::REG_GAIN_P,        {16'($urandom), c.gain_p});
        write_reg(psc_pkg::REG_GAIN_D,        {16'($urandom), c.gain_d});
        write_reg(psc_pkg::REG_GAIN_I,        {16'($urandom), c.gain_i});
        write_reg(psc_pkg::REG_TARGET,        {16'($urandom), c.target});
        write_reg(psc_pkg::REG_DRIVE_FLOOR,   c.drive_floor);
        write_reg(psc_pkg::REG_DRIVE_CEILING, c.drive_ceiling);
        write_reg(psc_pkg::REG_ACCUM_FLOOR,   c.accum_floor);
        write_reg(psc_pkg::REG_ACCUM_CEILING, c.accum_ceiling);
        settings_used++;
    endtask

    task automatic load_settings(input t_setting mode);
        psc_pkg::t_cfg c;
        c.gain_p        = pick_gain();
        c.gain_d        = pick_gain();
        c.gain_i        = pick_gain();
        c.target        = $urandom_range(0, 3) == 0 ? 16'sh8000 : 16'($urandom);
        c.drive_floor   = psc_pkg::BOUND_MIN;
        c.drive_ceiling = psc_pkg::BOUND_MAX;
        c.accum_floor   = psc_pkg::BOUND_MIN;
        c.accum_ceiling = psc_pkg::BOUND_MAX;
        case (mode)
            SET_EXTREME: begin
                c.gain_p = 16'sh7FFF;
                c.gain_d = 16'sh8000;
                c.gain_i = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                c.target = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            SET_NARROW: begin
                bound_pair(BND_NARROW, c.drive_floor, c.drive_ceiling);
                bound_pair(BND_NARROW, c.accum_floor, c.accum_ceiling);
            end
            SET_CROSSED: begin
                bound_pair(BND_CROSSED, c.drive_floor, c.drive_ceiling);
                bound_pair(BND_CROSSED, c.accum_floor, c.accum_ceiling);
            end
            SET_ANY: begin
                bound_pair(BND_ANY, c.drive_floor, c.drive_ceiling);
                bound_pair(BND_ANY, c.accum_floor, c.accum_ceiling);
            end
            SET_EQUAL: begin
                bound_pair(BND_EQUAL, c.drive_floor, c.drive_ceiling);
                bound_pair(BND_NARROW, c.accum_floor, c.accum_ceiling);
            end
            SET_WINDUP: begin
                c.gain_i = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                c.gain_p = c.gain_i;
                c.target = 16'sh7FFF;
            end
            default: ;
        endcase
        write_all(c);
    endtask

    task automatic drain();
        while (stim_q.size() != 0 || drive_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        if (took_sample) begin
            void'(stim_q.pop_front());
        end
        if (!push || took_sample) begin
            if (i_rst_n && stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                push          <= 1'b1;
                i_measurement <= stim_q[0];
            end else begin
                push          <= 1'b0;
                i_measurement <= 16'($urandom);
            end
        end
        pop <= !rcv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : result_check
        logic signed [psc_pkg::DRIVE_W-1:0] want;
        took_sample = i_rst_n && push && !full;
        if (took_sample) begin
            drive_q.push_back(next_drive(i_measurement));
            samples_sent++;
        end
        if (i_rst_n && push && full) begin
            stalled_offers++;
        end
        if (i_rst_n && pop && !empty) begin
            if (drive_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected drive transaction %0d with nothing outstanding",
                             o_drive);
                end
            end else begin
                want = drive_q.pop_front();
                if (o_drive !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("drive mismatch on transaction %0d: expected %0d, got %0d",
                                 drives_checked, want, o_drive);
                    end
                end
                drives_checked++;
            end
        end
    end

    initial begin : receiver_stall
        wait (stall_go);
        @(posedge i_clk);
        rcv_hold = 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        rcv_hold = 1'b0;
    end

    initial begin : stimulus
        t_setting      plan [9];
        psc_pkg::t_cfg unity;
        plan = '{SET_NARROW, SET_CROSSED, SET_EXTREME,
                 SET_ANY, SET_EQUAL, SET_NARROW,
                 SET_WINDUP, SET_CROSSED, SET_ANY};
        unity = '{gain_p: 16'sh0100, gain_d: 16'sh0080, gain_i: 16'sh0010,
                  target: 16'sd100,
                  drive_floor: psc_pkg::BOUND_MIN, drive_ceiling: psc_pkg::BOUND_MAX,
                  accum_floor: psc_pkg::BOUND_MIN, accum_ceiling: psc_pkg::BOUND_MAX};
        pid_cfg = '{gain_p: '0, gain_d: '0, gain_i: '0, target: '0,
                    drive_floor: psc_pkg::BOUND_MIN, drive_ceiling: psc_pkg::BOUND_MAX,
                    accum_floor: psc_pkg::BOUND_MIN, accum_ceiling: psc_pkg::BOUND_MAX};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        stim_q = {16'sh0000, 16'sh7FFF, 16'sh8000};
        drain();
        write_all(unity);
        stim_q = {16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                  16'sh0001, 16'sd100, 16'sh5555, 16'shAAAA, 16'sd99, 16'sd101};
        drain();
        load_settings(SET_CROSSED);
        stim_q = {16'sh7FFF, 16'sh8000, 16'sh0000, 16'sd100};
        drain();

        for (int seg = 0; seg < 9; seg++) begin
            case (seg / 3)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 52;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 7;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            load_settings(plan[seg]);
            // Wind-up needs about 260 saturating samples before the integral pins.
            for (int k = 0; k < (plan[seg] == SET_WINDUP ? 300 : 20); k++) begin
                stim_q.push_back(next_sample(plan[seg] == SET_WINDUP));
            end
            if (plan[seg] == SET_WINDUP) begin
                stall_go = 1'b1;
            end
            drain();
        end

        repeat (12) @(posedge i_clk);
        errors += drive_q.size();
        $display("Sent %0d samples and checked %0d drive values over %0d register settings.",
                 samples_sent, drives_checked, settings_used);
        $display("Covered crossed and equal bounds, integral wind-up and %0d stalled offers.",
                 stalled_offers);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/psc_pkg.sv
rtl/psc_fifo.sv
rtl/psc_front.sv
rtl/psc_back.sv
rtl/pid_step_clamped.sv
rtl/psc_checker.sv
tb/tb.sv
